// File: sv/wgdac_pkg.sv
package wgdac_pkg;

  // Default sizes of the sine path.
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF = 32;

  // Field and state widths.
  localparam int ELAPSED_W = 16;
  localparam int CODE_W = 12;
  localparam int WORD_W = 16;
  localparam int LEVEL_W = 16;
  localparam int TOTAL_W = 32;
  localparam int FREQ_W = 7;
  localparam int DUTY_W = 7;
  localparam int CTRL_W = 4;
  localparam int COUNT_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Shared multiplier: 33 x 17 signed gives a 50-bit product.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Quarter-wave table entries are Q15 values from 0 to 32768.
  localparam int ROM_W = 16;
  localparam int Q15_SHIFT = 15;
  localparam int Q30_SHIFT = 30;

  // Update intervals.
  localparam logic [TOTAL_W-1:0] SINE_INTERVAL = 32'd100;
  localparam logic signed [MUL_P_W-1:0] SQUARE_LIMIT = MUL_P_W'(2500);
  localparam logic signed [MUL_P_W-1:0] SAW_LIMIT = MUL_P_W'(10237500);
  // A first sawtooth product at or above 2^24 already exceeds the limit.
  localparam int SAW_CLAMP_W = 24;

  // Square wave duty compare: counter * 100 against duty * 4096.
  localparam int SQ_CMP_W = 23;
  localparam int DUTY_SCALE = 100;
  localparam int DUTY_SHIFT = 12;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
  localparam logic [COUNT_W-1:0] DUTY_PERIOD = 16'd4096;

  // Phase increment is freq_tenths * 2^PHASE_BITS / 100000.
  localparam int PHASE_DIVISOR = 100000;

  // Register reset values.
  localparam logic [FREQ_W-1:0] FREQ_RESET = 7'd10;
  localparam logic [CODE_W-1:0] HIGH_RESET = 12'hfff;
  localparam logic [CODE_W-1:0] LOW_RESET = 12'h000;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;
  localparam logic [CTRL_W-1:0] CTRL_RESET = 4'b0011;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_SAW,
    MODE_SINE,
    MODE_SQUARE
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MODE,
    CFG_FREQ,
    CFG_HIGH,
    CFG_LOW,
    CFG_DUTY,
    CFG_SLOPE,
    CFG_CONTROL
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SQ_MUL,
    ST_SQ_CMP,
    ST_SAW_MUL1,
    ST_SAW_MUL2,
    ST_SAW_CMP,
    ST_UPDATE,
    ST_SIN_ROM,
    ST_SIN_MUL,
    ST_SIN_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                       en;
    logic signed [MUL_A_W-1:0]  a;
    logic signed [MUL_B_W-1:0]  b;
  } mul_req_t;

  // sin(pi/2 * t) for t in Q30 on [0,1], odd polynomial up to t^9,
  // rounded to Q15 and limited to 1.0. Used only on constants.
  function automatic logic [ROM_W-1:0] quarter_sine_value(logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] p3;
    logic [63:0] p5;
    logic [63:0] p7;
    logic [63:0] p9;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] q;
    logic [63:0] v;
    t2 = (t * t) >> Q30_SHIFT;
    p3 = (t * t2) >> Q30_SHIFT;
    p5 = (p3 * t2) >> Q30_SHIFT;
    p7 = (p5 * t2) >> Q30_SHIFT;
    p9 = (p7 * t2) >> Q30_SHIFT;
    pos = ((64'd1686629713 * t) >> Q30_SHIFT) + ((64'd85569306 * p5) >> Q30_SHIFT)
        + ((64'd172272 * p9) >> Q30_SHIFT);
    neg = ((64'd693598668 * p3) >> Q30_SHIFT) + ((64'd5026995 * p7) >> Q30_SHIFT);
    q = (neg > pos) ? 64'd0 : pos - neg;
    v = (q + 64'd16384) >> Q15_SHIFT;
    return (v > 64'd32768) ? ROM_W'(32768) : v[ROM_W-1:0];
  endfunction

endpackage

// File: sv/wgdac_if.sv
interface wgdac_timing_if;
  import wgdac_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_us;
  modport source (output valid, output elapsed_us, input ready);
  modport sink (input valid, input elapsed_us, output ready);
endinterface

interface wgdac_result_if;
  import wgdac_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] sample_code;
  logic [WORD_W-1:0] dac_word;
  modport source (output valid, output sample_code, output dac_word, input ready);
  modport sink (input valid, input sample_code, input dac_word, output ready);
endinterface

interface wgdac_cfg_if;
  import wgdac_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/wgdac_mul.sv
module wgdac_mul (
  input  logic                                  clk,
  input  wgdac_pkg::mul_req_t                   req,
  output logic signed [wgdac_pkg::MUL_P_W-1:0]  product
);
  import wgdac_pkg::*;

  logic signed [MUL_P_W-1:0] full_product;

  // The product width equals the sum of the operand widths, so it never wraps.
  assign full_product = req.a * req.b;

  always_ff @(posedge clk) begin
    if (req.en) begin
      product <= full_product;
    end
  end

endmodule

// File: sv/wgdac_sine_rom.sv
module wgdac_sine_rom #(
  parameter int QUARTER_LEN = wgdac_pkg::SINE_TABLE_DEPTH_DEF / 4
) (
  input  logic                                 clk,
  input  logic [$clog2(QUARTER_LEN + 1)-1:0]   addr,
  output logic [wgdac_pkg::ROM_W-1:0]          data
);
  import wgdac_pkg::*;

  localparam int Entries = QUARTER_LEN + 1;

  logic [ROM_W-1:0] rom_table [Entries];

  // Entry k holds sin(pi/2 * k / QUARTER_LEN) in Q15.
  for (genvar k = 0; k < Entries; k++) begin : g_entry
    assign rom_table[k] = quarter_sine_value((64'(k) << Q30_SHIFT) / QUARTER_LEN);
  end

  always_ff @(posedge clk) begin
    data <= rom_table[addr];
  end

endmodule

// File: sv/waveform_generator_dac_core.sv
// Sequence: an accepted input passes the evaluate state; where the mode needs them, the
// square or sawtooth multiply and compare states; the update state; for sine, the table
// read, multiply and accumulate states; and the done state, which loads the output register.
// A new input transaction is taken only back in idle; a stalled sink adds its wait in done.
// Reset is synchronous and active high: registers take their defaults, all waveform
// state clears, and the block is ready in the first cycle after reset.
module waveform_generator_dac_core #(
  parameter int SINE_TABLE_DEPTH = wgdac_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS = wgdac_pkg::PHASE_BITS_DEF
) (
  input logic            clk,
  input logic            rst,
  wgdac_timing_if.sink   timing,
  wgdac_result_if.source result,
  wgdac_cfg_if.sink      cfg
);
  import wgdac_pkg::*;

  // The table index is the phase scaled by the table depth, keeping the bits above
  // the phase width. For a power-of-two depth this reduces to the top phase bits.
  localparam int QuarterLen = SINE_TABLE_DEPTH / 4;
  localparam int IdxW = $clog2(SINE_TABLE_DEPTH);
  localparam int ScaledW = PHASE_BITS + IdxW;
  localparam int RomAddrW = $clog2(QuarterLen + 1);
  localparam int FreqEntries = 1 << FREQ_W;
  localparam int PhaseDiv = PHASE_DIVISOR;
  localparam logic [IdxW:0] Quad1 = (IdxW + 1)'(QuarterLen);
  localparam logic [IdxW:0] Quad2 = (IdxW + 1)'(2 * QuarterLen);
  localparam logic [IdxW:0] Quad3 = (IdxW + 1)'(3 * QuarterLen);
  localparam logic [IdxW:0] Quad4 = (IdxW + 1)'(SINE_TABLE_DEPTH);

  state_t state;
  state_t state_next;

  // Configuration registers.
  mode_t             mode;
  logic [FREQ_W-1:0] freq_tenths;
  logic [CODE_W-1:0] high_code;
  logic [CODE_W-1:0] low_code;
  logic [DUTY_W-1:0] duty_percent;
  logic              slope_down;
  logic [CTRL_W-1:0] dac_control;

  // Waveform state.
  logic [TOTAL_W-1:0]    elapsed_total;
  logic [LEVEL_W-1:0]    sample_level;
  logic [LEVEL_W-1:0]    sample_level_next;
  logic [PHASE_BITS-1:0] sine_phase;
  logic [COUNT_W-1:0]    duty_counter;
  logic [COUNT_W-1:0]    duty_counter_next;

  // Output register.
  logic              out_valid;
  logic [CODE_W-1:0] out_code;
  logic [WORD_W-1:0] out_word;

  // Shared multiplier.
  mul_req_t                   mul_req;
  logic signed [MUL_P_W-1:0]  product;

  // Sine path.
  logic [PHASE_BITS-1:0] inc_table [FreqEntries];
  logic [ScaledW-1:0]    phase_scaled;
  logic [IdxW-1:0]       sine_idx;
  logic [IdxW:0]         idx_ext;
  logic                  sine_negative;
  logic [RomAddrW-1:0]   rom_addr;
  logic [ROM_W-1:0]      rom_data;
  logic [MUL_B_W-1:0]    sine_mag;

  // Level arithmetic.
  logic [TOTAL_W:0]            total_sum;
  logic [TOTAL_W-1:0]          total_sat;
  logic [CODE_W:0]             level_sum;
  logic [CODE_W-1:0]           mid_level;
  logic [CODE_W-1:0]           saw_span;
  logic signed [CODE_W:0]      level_diff;
  logic signed [CODE_W:0]      level_round;
  logic signed [CODE_W:0]      half_span;
  logic [SAW_CLAMP_W-1:0]      saw_clamped;
  logic signed [MUL_P_W-1:0]   mid_scaled;
  logic signed [MUL_P_W-1:0]   sine_acc;
  logic [LEVEL_W-1:0]          sine_level;
  logic [LEVEL_W-1:0]          level_dec;
  logic [LEVEL_W-1:0]          level_inc;
  logic [COUNT_W-1:0]          count_inc;
  logic [SQ_CMP_W-1:0]         count_scaled;
  logic [SQ_CMP_W-1:0]         duty_scaled;
  logic                        out_free;

  // Phase increment for every frequency setting, fixed at elaboration.
  for (genvar f = 0; f < FreqEntries; f++) begin : g_inc
    assign inc_table[f] = PHASE_BITS'((64'(f) << PHASE_BITS) / PhaseDiv);
  end

  wgdac_mul u_mul (
    .clk     (clk),
    .req     (mul_req),
    .product (product)
  );

  wgdac_sine_rom #(
    .QUARTER_LEN (QuarterLen)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  // Handshakes. The block takes a new transaction only from the idle state; the
  // output register lets a finished result wait while the next item is accepted.
  assign timing.ready       = (state == ST_IDLE);
  assign cfg.ready          = 1'b1;
  assign result.valid       = out_valid;
  assign result.sample_code = out_code;
  assign result.dac_word    = out_word;
  assign out_free           = !out_valid || result.ready;

  // The running total saturates rather than wrapping.
  assign total_sum = {1'b0, elapsed_total} + (TOTAL_W + 1)'(timing.elapsed_us);
  assign total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  // Mid level and half span of the output range. The half span truncates toward
  // zero, so a negative odd difference is rounded up before the shift.
  assign level_sum   = {1'b0, high_code} + {1'b0, low_code};
  assign mid_level   = level_sum[CODE_W:1];
  assign saw_span    = high_code - low_code;
  assign level_diff  = $signed({1'b0, high_code}) - $signed({1'b0, low_code});
  assign level_round = level_diff + $signed((CODE_W + 1)'(level_diff[CODE_W]));
  assign half_span   = level_round >>> 1;

  // The first sawtooth product is clamped so that the second pass stays narrow.
  assign saw_clamped = (product[MUL_P_W-1:SAW_CLAMP_W] != '0) ? '1
                                                            : product[SAW_CLAMP_W-1:0];

  // Quarter-wave folding: the second and fourth quadrants read the table mirrored,
  // the third and fourth negate the value.
  assign phase_scaled = ScaledW'(sine_phase) * ScaledW'(SINE_TABLE_DEPTH);
  assign sine_idx     = phase_scaled[PHASE_BITS +: IdxW];
  assign idx_ext      = {1'b0, sine_idx};
  assign sine_mag     = {1'b0, rom_data};

  always_comb begin
    priority if (idx_ext < Quad1) begin
      rom_addr      = RomAddrW'(idx_ext);
      sine_negative = 1'b0;
    end else if (idx_ext < Quad2) begin
      rom_addr      = RomAddrW'(Quad2 - idx_ext);
      sine_negative = 1'b0;
    end else if (idx_ext < Quad3) begin
      rom_addr      = RomAddrW'(idx_ext - Quad2);
      sine_negative = 1'b1;
    end else begin
      rom_addr      = RomAddrW'(Quad4 - idx_ext);
      sine_negative = 1'b1;
    end
  end

  // Sine level: mid * 2^15 + half * sin, negative results clamp to zero.
  assign mid_scaled = $signed(MUL_P_W'(mid_level) << Q15_SHIFT);
  assign sine_acc   = mid_scaled + product;
  assign sine_level = sine_acc[MUL_P_W-1] ? '0
                                          : sine_acc[Q15_SHIFT +: LEVEL_W];

  // Square wave duty compare.
  assign count_inc    = duty_counter + 1'b1;
  assign count_scaled = SQ_CMP_W'(count_inc) * SQ_CMP_W'(DUTY_SCALE);
  assign duty_scaled  = SQ_CMP_W'(duty_percent) << DUTY_SHIFT;

  assign level_dec = sample_level - 1'b1;
  assign level_inc = sample_level + 1'b1;

  // New level and duty count on an update. Zero frequency holds the mid level and
  // takes precedence over every mode; the sine level is settled later.
  always_comb begin
    sample_level_next = sample_level;
    duty_counter_next = duty_counter;
    priority if (freq_tenths == '0) begin
      sample_level_next = LEVEL_W'(mid_level);
    end else if (mode == MODE_SAW) begin
      if (slope_down) begin
        if (level_dec <= LEVEL_W'(low_code)) begin
          sample_level_next = level_dec + LEVEL_W'(high_code) - LEVEL_W'(low_code);
        end else begin
          sample_level_next = level_dec;
        end
      end else begin
        if (level_inc >= LEVEL_W'(high_code)) begin
          sample_level_next = LEVEL_W'(low_code);
        end else begin
          sample_level_next = level_inc;
        end
      end
    end else if (mode == MODE_SQUARE) begin
      duty_counter_next = count_inc;
      if (count_scaled < duty_scaled) begin
        sample_level_next = LEVEL_W'(high_code);
      end else if (duty_percent < DUTY_FULL) begin
        sample_level_next = LEVEL_W'(low_code);
        if (count_inc > DUTY_PERIOD) begin
          duty_counter_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: picks the interval test for the mode, drives the shared multiplier
  // and steps through the sine table read before the result is registered.
  always_comb begin
    state_next = state;
    mul_req    = '0;
    unique case (state)
      ST_IDLE: begin
        if (timing.valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (mode == MODE_OFF) begin
          state_next = ST_IDLE;
        end else if (mode == MODE_SINE) begin
          state_next = (elapsed_total > SINE_INTERVAL) ? ST_UPDATE : ST_IDLE;
        end else if (freq_tenths == '0) begin
          state_next = (elapsed_total != '0) ? ST_UPDATE : ST_IDLE;
        end else if (mode == MODE_SQUARE) begin
          state_next = ST_SQ_MUL;
        end else if (high_code < low_code) begin
          state_next = ST_UPDATE;
        end else if (high_code > low_code) begin
          state_next = ST_SAW_MUL1;
        end else begin
          // Equal levels give an unbounded sawtooth interval.
          state_next = ST_IDLE;
        end
      end
      ST_SQ_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, elapsed_total};
        mul_req.b  = MUL_B_W'(freq_tenths);
        state_next = ST_SQ_CMP;
      end
      ST_SQ_CMP: begin
        state_next = (product > SQUARE_LIMIT) ? ST_UPDATE : ST_IDLE;
      end
      ST_SAW_MUL1: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, elapsed_total};
        mul_req.b  = MUL_B_W'(freq_tenths);
        state_next = ST_SAW_MUL2;
      end
      ST_SAW_MUL2: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(saw_clamped);
        mul_req.b  = MUL_B_W'(saw_span);
        state_next = ST_SAW_CMP;
      end
      ST_SAW_CMP: begin
        state_next = (product > SAW_LIMIT) ? ST_UPDATE : ST_IDLE;
      end
      ST_UPDATE: begin
        state_next = (mode == MODE_SINE && freq_tenths != '0) ? ST_SIN_ROM : ST_DONE;
      end
      ST_SIN_ROM: begin
        state_next = ST_SIN_MUL;
      end
      ST_SIN_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(half_span);
        mul_req.b  = sine_negative ? -$signed(sine_mag) : $signed(sine_mag);
        state_next = ST_SIN_ACC;
      end
      ST_SIN_ACC: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_OFF;
      freq_tenths  <= FREQ_RESET;
      high_code    <= HIGH_RESET;
      low_code     <= LOW_RESET;
      duty_percent <= DUTY_RESET;
      slope_down   <= 1'b0;
      dac_control  <= CTRL_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_MODE:    mode         <= mode_t'(cfg.data[1:0]);
        CFG_FREQ:    freq_tenths  <= cfg.data[FREQ_W-1:0];
        CFG_HIGH:    high_code    <= cfg.data[CODE_W-1:0];
        CFG_LOW:     low_code     <= cfg.data[CODE_W-1:0];
        CFG_DUTY:    duty_percent <= cfg.data[DUTY_W-1:0];
        CFG_SLOPE:   slope_down   <= cfg.data[0];
        CFG_CONTROL: dac_control  <= cfg.data[CTRL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Waveform state. The total is cleared when the mode is off and whenever a new
  // sample is produced.
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_total <= '0;
      sample_level  <= '0;
      sine_phase    <= '0;
      duty_counter  <= '0;
    end else begin
      if (state == ST_IDLE && timing.valid) begin
        elapsed_total <= total_sat;
      end else if (state == ST_EVAL && mode == MODE_OFF) begin
        elapsed_total <= '0;
      end else if (state == ST_UPDATE) begin
        elapsed_total <= '0;
      end
      if (state == ST_UPDATE) begin
        sample_level <= sample_level_next;
        duty_counter <= duty_counter_next;
        if (mode == MODE_SINE && freq_tenths != '0) begin
          sine_phase <= sine_phase + inc_table[freq_tenths];
        end
      end else if (state == ST_SIN_ACC) begin
        sample_level <= sine_level;
      end
    end
  end

  // Output register: holds one result until the sink completes its transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_code <= sample_level[CODE_W-1:0];
      out_word <= {dac_control, sample_level[CODE_W-1:0]};
    end
  end

endmodule

// File: sim/waveform_generator_dac_core_checker.sv
module waveform_generator_dac_core_checker
  import wgdac_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  wgdac_timing_if        timing,
  wgdac_result_if        result,
  wgdac_cfg_if           cfg,
  output int unsigned    faults,
  output int unsigned    samples_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUARTER_LEN = SINE_TABLE_DEPTH / 4;
  localparam longint unsigned PHASE_MASK = (64'd1 << PHASE_BITS) - 64'd1;
  localparam longint unsigned PHASE_STEP_DIV = 64'd100000;
  localparam longint unsigned SQUARE_THRESHOLD = 64'd2500;
  localparam longint unsigned SAW_THRESHOLD = 64'd10237500;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CODE_W-1:0] sample_code;
    logic [WORD_W-1:0] dac_word;
  } dac_sample_t;

  // Register copies.
  mode_t              cur_mode;
  logic [FREQ_W-1:0]  freq;
  logic [CODE_W-1:0]  hi;
  logic [CODE_W-1:0]  lo;
  logic [DUTY_W-1:0]  duty;
  logic               slope;
  logic [CTRL_W-1:0]  ctrl;

  // Waveform state.
  logic [TOTAL_W-1:0] total;
  logic [LEVEL_W-1:0] level;
  longint unsigned    phase;
  logic [COUNT_W-1:0] duty_cnt;

  longint             quarter_rom[0:QUARTER_LEN];
  dac_sample_t        samples_due[$];
  int unsigned        fault_total = 0;

  // sin(pi/2 * t) with t and the result in Q30, odd polynomial up to t^9.
  function automatic longint unsigned quarter_wave_q30(input longint unsigned t);
    longint unsigned t2, p3, p5, p7, p9, pos, neg;
    t2 = (t * t) >> 30;
    p3 = (t * t2) >> 30;
    p5 = (p3 * t2) >> 30;
    p7 = (p5 * t2) >> 30;
    p9 = (p7 * t2) >> 30;
    pos = ((64'd1686629713 * t) >> 30) + ((64'd85569306 * p5) >> 30)
        + ((64'd172272 * p9) >> 30);
    neg = ((64'd693598668 * p3) >> 30) + ((64'd5026995 * p7) >> 30);
    return (neg > pos) ? 64'd0 : pos - neg;
  endfunction

  initial begin
    longint unsigned t;
    longint unsigned v;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      t = (64'(k) << 30) / QUARTER_LEN;
      v = (quarter_wave_q30(t) + 64'd16384) >> 15;
      quarter_rom[k] = (v > 64'd32768) ? 64'sd32768 : longint'(v);
    end
  end

  function automatic longint sine_q15(input longint unsigned ph);
    longint unsigned idx;
    idx = (ph * 64'(SINE_TABLE_DEPTH)) >> PHASE_BITS;
    if (idx >= 4 * QUARTER_LEN) idx = 4 * QUARTER_LEN - 1;
    if (idx < QUARTER_LEN) return quarter_rom[idx];
    if (idx < 2 * QUARTER_LEN) return quarter_rom[2 * QUARTER_LEN - idx];
    if (idx < 3 * QUARTER_LEN) return -quarter_rom[idx - 2 * QUARTER_LEN];
    return -quarter_rom[4 * QUARTER_LEN - idx];
  endfunction

  // Adds the elapsed time and, when the interval is passed, produces the next sample.
  function automatic bit advance_waveform(input logic [ELAPSED_W-1:0] us,
                                          output dac_sample_t s);
    longint unsigned sum;
    longint          half, mid, acc;
    bit              fire;
    fire = 1'b0;
    sum = 64'(total) + 64'(us);
    total = (sum > 64'hffff_ffff) ? '1 : sum[TOTAL_W-1:0];
    if (cur_mode == MODE_OFF) begin
      total = '0;
      return 1'b0;
    end
    if (cur_mode == MODE_SINE) fire = total > SINE_INTERVAL;
    else if (freq == '0) fire = total != '0;
    else if (cur_mode == MODE_SQUARE) fire = 64'(total) * 64'(freq) > SQUARE_THRESHOLD;
    else if (hi < lo) fire = 1'b1;
    else if (hi > lo) fire = 64'(total) * 64'(freq) * 64'(hi - lo) > SAW_THRESHOLD;
    if (!fire) return 1'b0;
    total = '0;

    if (freq == '0) begin
      level = LEVEL_W'((32'(hi) + 32'(lo)) / 2);
    end else if (cur_mode == MODE_SAW) begin
      if (slope) begin
        level = level - 16'd1;
        if (level <= LEVEL_W'(lo)) level = level + LEVEL_W'(hi) - LEVEL_W'(lo);
      end else begin
        level = level + 16'd1;
        if (level >= LEVEL_W'(hi)) level = LEVEL_W'(lo);
      end
    end else if (cur_mode == MODE_SINE) begin
      phase = (phase + ((64'(freq) << PHASE_BITS) / PHASE_STEP_DIV)) & PHASE_MASK;
      half = (longint'(hi) - longint'(lo)) / 2;
      mid = (longint'(hi) + longint'(lo)) / 2;
      acc = mid * 32768 + half * sine_q15(phase);
      level = (acc < 0) ? '0 : LEVEL_W'(acc >>> 15);
    end else begin
      duty_cnt = duty_cnt + 16'd1;
      if (32'(duty_cnt) * 32'd100 < 32'(duty) * 32'd4096) begin
        level = LEVEL_W'(hi);
      end else if (duty < DUTY_FULL) begin
        level = LEVEL_W'(lo);
        if (duty_cnt > DUTY_PERIOD) duty_cnt = '0;
      end
    end
    s.sample_code = level[CODE_W-1:0];
    s.dac_word = {ctrl, level[CODE_W-1:0]};
    return 1'b1;
  endfunction

  task automatic report_fault(input string msg);
    if (fault_total < REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
    fault_total++;
  endtask

  always @(posedge clk) begin
    dac_sample_t want;
    dac_sample_t got;
    if (rst) begin
      cur_mode = MODE_OFF;
      freq = FREQ_RESET;
      hi = HIGH_RESET;
      lo = LOW_RESET;
      duty = DUTY_RESET;
      slope = 1'b0;
      ctrl = CTRL_RESET;
      total = '0;
      level = '0;
      phase = '0;
      duty_cnt = '0;
      samples_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MODE:    cur_mode = mode_t'(cfg.data[1:0]);
          CFG_FREQ:    freq = cfg.data[FREQ_W-1:0];
          CFG_HIGH:    hi = cfg.data[CODE_W-1:0];
          CFG_LOW:     lo = cfg.data[CODE_W-1:0];
          CFG_DUTY:    duty = cfg.data[DUTY_W-1:0];
          CFG_SLOPE:   slope = cfg.data[0];
          CFG_CONTROL: ctrl = cfg.data[CTRL_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        got.sample_code = result.sample_code;
        got.dac_word = result.dac_word;
        if (samples_due.size() == 0) begin
          report_fault($sformatf("unexpected sample: sample_code %03h dac_word %04h",
                                 got.sample_code, got.dac_word));
        end else begin
          want = samples_due.pop_front();
          if (got.sample_code !== want.sample_code)
            report_fault($sformatf("sample_code expected %03h got %03h",
                                   want.sample_code, got.sample_code));
          if (got.dac_word !== want.dac_word)
            report_fault($sformatf("dac_word expected %04h got %04h",
                                   want.dac_word, got.dac_word));
        end
      end
      if (timing.valid && timing.ready) begin
        if (advance_waveform(timing.elapsed_us, want)) samples_due.push_back(want);
      end
    end
    samples_outstanding <= samples_due.size();
    faults <= fault_total;
  end

endmodule

// File: sim/waveform_generator_dac_core_tb.sv
module waveform_generator_dac_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wgdac_pkg::*;

  // Quiet cycles after the last predicted sample: enough to cover any work still in
  // flight on an item that produces no sample.
  localparam int SETTLE_CYCLES = 16;
  // Cycles without any transaction on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_SETTINGS = 16;
  localparam int ITEMS_PER_SETTING = 117;
  // No register lives at this index; a write there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;

  logic        clk;
  logic        rst;
  int unsigned faults;
  int unsigned samples_outstanding;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned quiet_cycles;

  wgdac_timing_if timing();
  wgdac_result_if result();
  wgdac_cfg_if    cfg();

  waveform_generator_dac_core u_top (
    .clk    (clk),
    .rst    (rst),
    .timing (timing),
    .result (result),
    .cfg    (cfg)
  );

  waveform_generator_dac_core_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .timing              (timing),
    .result              (result),
    .cfg                 (cfg),
    .faults              (faults),
    .samples_outstanding (samples_outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The sample consumer stalls at random; the stall rate is set per phase of the run.
  always @(posedge clk) begin
    result.ready <= !rst && ($urandom_range(99) >= rx_stall_pct);
  end

  // The watchdog restarts on any transaction, so a hang anywhere ends the run.
  always @(posedge clk) begin
    if (rst || (timing.valid && timing.ready) || (result.valid && result.ready)
        || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Fills the unused upper bits of a register write with random noise; the block
  // must only look at the bits of the register itself.
  function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] field,
                                                       input int width);
    logic [CFG_DATA_W-1:0] keep;
    keep = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
    return (CFG_DATA_W'($urandom) & ~keep) | (field & keep);
  endfunction

  // Offers one timing transaction, after a random number of idle cycles, and returns
  // on the clock edge where it is taken. Valid stays high so that back-to-back
  // transactions need no second assignment in the same time step.
  task automatic send_elapsed(input logic [ELAPSED_W-1:0] us);
    while ($urandom_range(99) < tx_idle_pct) begin
      timing.valid <= 1'b0;
      @(posedge clk);
    end
    timing.valid <= 1'b1;
    timing.elapsed_us <= us;
    @(posedge clk);
    while (!timing.ready) @(posedge clk);
  endtask

  // Register write; the caller drops valid once its last write has been taken.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // Stops the timing stream, waits for every predicted sample to come out and then
  // lets the block finish whatever item is still in flight.
  task automatic wait_idle();
    timing.valid <= 1'b0;
    @(posedge clk);
    while (samples_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes every register once the block is idle. The microsecond total and the
  // waveform state are not touched by a register write, so they carry over.
  task automatic apply_setting(input mode_t m, input logic [FREQ_W-1:0] f,
                               input logic [CODE_W-1:0] h, input logic [CODE_W-1:0] l,
                               input logic [DUTY_W-1:0] d, input logic s,
                               input logic [CTRL_W-1:0] c);
    wait_idle();
    write_reg(CFG_MODE, with_noise(CFG_DATA_W'(m), $bits(mode_t)));
    write_reg(CFG_FREQ, with_noise(CFG_DATA_W'(f), FREQ_W));
    write_reg(CFG_HIGH, with_noise(CFG_DATA_W'(h), CODE_W));
    write_reg(CFG_LOW, with_noise(CFG_DATA_W'(l), CODE_W));
    write_reg(CFG_DUTY, with_noise(CFG_DATA_W'(d), DUTY_W));
    write_reg(CFG_SLOPE, with_noise(CFG_DATA_W'(s), 1));
    write_reg(CFG_CONTROL, with_noise(CFG_DATA_W'(c), CTRL_W));
    cfg.valid <= 1'b0;
  endtask

  initial begin
    int unsigned           pick;
    int unsigned           span_a;
    int unsigned           span_b;
    mode_t                 m;
    logic [FREQ_W-1:0]     f;
    logic [CODE_W-1:0]     h;
    logic [CODE_W-1:0]     l;
    logic [DUTY_W-1:0]     d;
    logic [ELAPSED_W-1:0]  us;

    timing.valid = 1'b0;
    timing.elapsed_us = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    tx_idle_pct = 14;
    rx_stall_pct = 87;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The block comes out of reset switched off: time is thrown
    // away and no sample appears, even for a full-scale transaction.
    send_elapsed('1);
    send_elapsed(16'd1);

    // Rising sawtooth over the full code range. A single microsecond does not
    // reach the interval; a large step does.
    apply_setting(MODE_SAW, 7'd100, 12'hfff, 12'h000, 7'd50, 1'b0, 4'h0);
    @(posedge clk);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg.valid <= 1'b0;
    send_elapsed('1);
    send_elapsed(16'd1);
    send_elapsed(16'h8000);

    // Falling sawtooth on a narrow span with a frequency above the nominal range,
    // so the level wraps back up to the top of the span.
    apply_setting(MODE_SAW, 7'd127, 12'd10, 12'd5, 7'd50, 1'b1, 4'hf);
    repeat (3) send_elapsed('1);

    // Equal levels: the sawtooth interval is never reached.
    apply_setting(MODE_SAW, 7'd50, 12'd2000, 12'd2000, 7'd50, 1'b0, 4'h5);
    repeat (2) send_elapsed('1);

    // High below low: the sawtooth fires on every transaction.
    apply_setting(MODE_SAW, 7'd50, 12'd100, 12'd3000, 7'd50, 1'b0, 4'ha);
    send_elapsed(16'd1);
    send_elapsed(16'd2);

    // Zero frequency holds the mid level, in square and in sawtooth mode.
    apply_setting(MODE_SQUARE, 7'd0, 12'hfff, 12'h001, 7'd50, 1'b0, 4'h3);
    send_elapsed(16'd1);
    apply_setting(MODE_SAW, 7'd0, 12'd300, 12'd100, 7'd50, 1'b1, 4'hc);
    send_elapsed(16'd1);

    // Sine fires only once the total is strictly above 100 microseconds.
    apply_setting(MODE_SINE, 7'd100, 12'hfff, 12'h000, 7'd50, 1'b0, 4'h3);
    send_elapsed(16'd101);
    send_elapsed(16'd100);
    send_elapsed(16'd1);
    send_elapsed('1);

    // Square at the duty extremes, including a duty above 100 percent.
    apply_setting(MODE_SQUARE, 7'd100, 12'hfff, 12'h000, 7'd0, 1'b0, 4'h3);
    send_elapsed('1);
    apply_setting(MODE_SQUARE, 7'd100, 12'hfff, 12'h000, 7'd100, 1'b0, 4'h3);
    send_elapsed('1);
    apply_setting(MODE_SQUARE, 7'd100, 12'hfff, 12'h000, 7'd127, 1'b0, 4'h3);
    send_elapsed('1);

    // Square at the lowest frequency: exactly the interval does not fire.
    apply_setting(MODE_SQUARE, 7'd1, 12'hfff, 12'h000, 7'd50, 1'b0, 4'h3);
    send_elapsed(16'd2500);
    send_elapsed(16'd1);

    // Random part. Each setting is drawn with mostly sane values and now and then
    // an odd one: mode off, zero or out-of-range frequency, equal or swapped
    // levels, duty above 100 percent. The first third runs with a slow consumer,
    // the second with a slow producer, the last with neither stalling.
    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      if (s == RANDOM_SETTINGS / 3) begin
        tx_idle_pct = 87;
        rx_stall_pct = 14;
      end else if (s == 2 * RANDOM_SETTINGS / 3) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      pick = $urandom_range(9);
      m = (pick == 0) ? MODE_OFF : mode_t'(2'(1 + pick % 3));
      pick = $urandom_range(9);
      if (pick == 0) f = '0;
      else if (pick == 1) f = FREQ_W'($urandom_range(127, 101));
      else f = FREQ_W'($urandom_range(100, 1));
      span_a = $urandom_range(4095);
      span_b = $urandom_range(4095);
      pick = $urandom_range(9);
      if (pick == 0) begin
        h = CODE_W'(span_a);
        l = CODE_W'(span_a);
      end else if (pick == 1) begin
        h = CODE_W'((span_a < span_b) ? span_a : span_b);
        l = CODE_W'((span_a < span_b) ? span_b : span_a);
      end else begin
        h = CODE_W'((span_a < span_b) ? span_b : span_a);
        l = CODE_W'((span_a < span_b) ? span_a : span_b);
      end
      d = ($urandom_range(9) == 0) ? DUTY_W'($urandom_range(127, 101))
                                   : DUTY_W'($urandom_range(100));
      apply_setting(m, f, h, l, d, 1'($urandom), CTRL_W'($urandom));
      // Mostly short steps so that the total builds up over several transactions,
      // with some long ones that cross the interval at once.
      repeat (ITEMS_PER_SETTING) begin
        pick = $urandom_range(99);
        if (pick < 45) us = ELAPSED_W'($urandom_range(50, 1));
        else if (pick < 80) us = ELAPSED_W'($urandom_range(1000, 1));
        else us = ELAPSED_W'($urandom_range(65535, 1));
        send_elapsed(us);
      end
    end

    wait_idle();
    if (faults == 0 && samples_outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/wgdac_pkg.sv
sv/wgdac_if.sv
sv/wgdac_mul.sv
sv/wgdac_sine_rom.sv
sv/waveform_generator_dac_core.sv
sim/waveform_generator_dac_core_checker.sv
sim/waveform_generator_dac_core_tb.sv
